### rtl/lps_pkg.sv
// Package for the LED pattern sequencer: sizes, command codes, table entry
// type and the microprogram held in a read-only table.
// Depends on nothing; the top level and lps_useq use it by scoped names.
`default_nettype none

package lps_pkg;

  // Step table depth; a power of two so that addresses wrap naturally.
  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LED_COUNT   = 2;

  typedef logic [ADDR_W-1:0] addr_t;

  // Command codes of an input transfer
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // Special durations
  localparam logic [15:0] DUR_STOP = 16'd0;
  localparam logic [15:0] DUR_LOOP = 16'd1;

  localparam logic [15:0] RESTART_DELAY_RESET = 16'd10;

  // Register index decoded from paddr[2]
  localparam logic REG_RESTART_DELAY = 1'b0;

  typedef struct packed {
    logic        led;
    logic [7:0]  value;
    logic [15:0] duration;
  } entry_t;

  // Datapath operation selected by a control word
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_TICK   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_START  = 3'd3,
    OP_REPORT = 3'd4
  } op_e;

  // Microprogram addresses
  typedef logic [2:0] upc_t;
  localparam upc_t UPC_FETCH  = 3'd0;
  localparam upc_t UPC_TICK   = 3'd1;
  localparam upc_t UPC_WRITE  = 3'd2;
  localparam upc_t UPC_START  = 3'd3;
  localparam upc_t UPC_REPORT = 3'd4;

  typedef struct packed {
    logic accept;    // take an input transfer in this step
    logic dispatch;  // jump on the command of the accepted transfer
    logic wait_out;  // hold until the result register is free
    op_e  op;
    upc_t next;
  } uword_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    logic in_ready;
    logic take;      // input transfer completes this cycle
    logic commit;    // apply op and load the result register
    op_e  op;
  } ctrl_t;

  function automatic uword_t ucode(input upc_t upc);
    uword_t w;
    w = '{accept: 1'b1, dispatch: 1'b1, wait_out: 1'b0, op: OP_NONE, next: UPC_FETCH};
    case (upc)
      UPC_FETCH: begin
        w = '{accept: 1'b1, dispatch: 1'b1, wait_out: 1'b0, op: OP_NONE, next: UPC_FETCH};
      end
      UPC_TICK: begin
        w = '{accept: 1'b0, dispatch: 1'b0, wait_out: 1'b1, op: OP_TICK, next: UPC_FETCH};
      end
      UPC_WRITE: begin
        w = '{accept: 1'b0, dispatch: 1'b0, wait_out: 1'b1, op: OP_WRITE, next: UPC_FETCH};
      end
      UPC_START: begin
        w = '{accept: 1'b0, dispatch: 1'b0, wait_out: 1'b1, op: OP_START, next: UPC_FETCH};
      end
      UPC_REPORT: begin
        w = '{accept: 1'b0, dispatch: 1'b0, wait_out: 1'b1, op: OP_REPORT, next: UPC_FETCH};
      end
      default: begin
        w = '{accept: 1'b1, dispatch: 1'b1, wait_out: 1'b0, op: OP_NONE, next: UPC_FETCH};
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/lps_in_if.sv
// Input channel of the LED pattern sequencer: valid/ready and the command
// payload. Depends on nothing.
`default_nettype none

interface lps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [5:0]  index;
  logic        entry_led;
  logic [7:0]  entry_value;
  logic [15:0] entry_duration;

  modport source (
    output valid, cmd, index, entry_led, entry_value, entry_duration,
    input  ready
  );
  modport sink (
    input  valid, cmd, index, entry_led, entry_value, entry_duration,
    output ready
  );
endinterface

`default_nettype wire

### rtl/lps_out_if.sv
// Result channel of the LED pattern sequencer: valid/ready and the status
// payload. Depends on nothing.
`default_nettype none

interface lps_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] led_levels;
  logic       busy_res;
  logic [5:0] current_step;

  modport source (
    output valid, led_levels, busy_res, current_step,
    input  ready
  );
  modport sink (
    input  valid, led_levels, busy_res, current_step,
    output ready
  );
endinterface

`default_nettype wire

### rtl/led_pattern_sequencer_unit.sv
// LED pattern sequencer top level: step table memory, pattern state and the
// result register, driven by the microprogram in lps_useq. Depends on
// lps_pkg, lps_in_if, lps_out_if and lps_useq.
// A transfer is taken in the fetch step and executed in the execute step,
// which also loads the result register; the result is offered in the
// cycle after the execute step. A new transfer is taken only after the
// execute step, as set by the fetch/execute microprogram; a full result register holds execute.
// Reset: asynchronous, active low; clears pattern state, LEDs and the result
// valid flag, sets restart_delay to 10. The step table is not cleared.
`default_nettype none

module led_pattern_sequencer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  lps_in_if.sink           req_i,
  lps_out_if.source        res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  lps_pkg::ctrl_t ctrl;
  logic           out_free;

  // Latched input transfer
  logic [5:0]     idx_q;
  lps_pkg::entry_t wentry_q;

  // Step table and its registered read port
  lps_pkg::entry_t mem [lps_pkg::TABLE_DEPTH];
  lps_pkg::entry_t rd_q;

  // Pattern state
  lps_pkg::addr_t ptr_q, ptr_d;
  lps_pkg::addr_t base_q, base_d;
  logic [7:0]     loop_q, loop_d;
  logic [15:0]    cd_q, cd_d;
  logic           run_q, run_d;
  logic [1:0]     led_q, led_d;
  logic [15:0]    delay_q;

  lps_pkg::addr_t cur_addr;
  lps_pkg::addr_t next_addr;
  logic [7:0]     loop_inc;

  // Result register
  logic           out_valid_q;
  logic [1:0]     out_led_q;
  logic           out_busy_q;
  logic [5:0]     out_step_q;

  assign out_free = ~out_valid_q | res_o.ready;

  lps_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_cmd_i   (req_i.cmd),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  assign req_i.ready = ctrl.in_ready;

  // Hold the transfer for the execute step; the command itself is consumed
  // by the dispatch jump.
  always_ff @(posedge clk_i) begin
    if (ctrl.take) begin
      idx_q             <= req_i.index;
      wentry_q.led      <= req_i.entry_led;
      wentry_q.value    <= req_i.entry_value;
      wentry_q.duration <= req_i.entry_duration;
    end
  end

  assign cur_addr = base_q + ptr_q;

  // Read the current entry every cycle. The state does not move while the
  // sequencer waits in fetch, so at the tick step rd_q holds the entry that
  // is about to run; table writes only happen in the write step.
  always_ff @(posedge clk_i) begin
    if (ctrl.commit && ctrl.op == lps_pkg::OP_WRITE) begin
      mem[lps_pkg::addr_t'(idx_q)] <= wentry_q;
    end
    rd_q <= mem[cur_addr];
  end

  assign loop_inc = loop_q + 8'd1;

  always_comb begin
    ptr_d  = ptr_q;
    base_d = base_q;
    loop_d = loop_q;
    cd_d   = cd_q;
    run_d  = run_q;
    led_d  = led_q;
    case (ctrl.op)
      lps_pkg::OP_TICK: begin
        if (run_q) begin
          if (cd_q > 16'd1) begin
            cd_d = cd_q - 16'd1;
          end else begin
            cd_d = 16'd0;
            if (rd_q.duration == lps_pkg::DUR_LOOP) begin
              // Loop marker: count passes when a limit is given
              if (rd_q.value != 8'd0) begin
                loop_d = loop_inc;
              end
              if (rd_q.value != 8'd0 && loop_inc == rd_q.value) begin
                run_d = 1'b0;
              end else begin
                ptr_d = '0;
                cd_d  = delay_q;
              end
            end else begin
              // LED numbers beyond the fitted LEDs leave the outputs alone
              if (int'(rd_q.led) < lps_pkg::LED_COUNT) begin
                led_d[rd_q.led] = (rd_q.value != 8'd0);
              end
              if (rd_q.duration == lps_pkg::DUR_STOP) begin
                run_d = 1'b0;
              end else begin
                cd_d  = rd_q.duration;
                ptr_d = ptr_q + lps_pkg::addr_t'(1);
              end
            end
          end
        end
      end
      lps_pkg::OP_START: begin
        ptr_d  = '0;
        loop_d = 8'd0;
        led_d  = 2'b00;
        base_d = lps_pkg::addr_t'(idx_q);
        cd_d   = delay_q;
        run_d  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign next_addr = base_d + ptr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      base_q <= '0;
      loop_q <= 8'd0;
      cd_q   <= 16'd0;
      run_q  <= 1'b0;
      led_q  <= 2'b00;
    end else if (ctrl.commit) begin
      ptr_q  <= ptr_d;
      base_q <= base_d;
      loop_q <= loop_d;
      cd_q   <= cd_d;
      run_q  <= run_d;
      led_q  <= led_d;
    end
  end

  // Result register: load on commit, drop once the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      out_led_q  <= led_d;
      out_busy_q <= run_d;
      out_step_q <= 6'(next_addr);
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.led_levels   = out_led_q;
  assign res_o.busy_res     = out_busy_q;
  assign res_o.current_step = out_step_q;

  // Configuration: restart_delay at byte address 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= lps_pkg::RESTART_DELAY_RESET;
    end else if (psel && penable && pwrite && paddr[2] == lps_pkg::REG_RESTART_DELAY) begin
      delay_q <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == lps_pkg::REG_RESTART_DELAY) ? {16'd0, delay_q} : 32'd0;

endmodule

`default_nettype wire

### rtl/lps_useq.sv
// Microprogram sequencer: step counter, control word table lookup and the
// command dispatch jump. Depends on lps_pkg.
`default_nettype none

module lps_useq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    in_cmd_i,
  input  wire logic          out_free_i,
  output lps_pkg::ctrl_t     ctrl_o
);

  lps_pkg::upc_t   upc_q, upc_d;
  lps_pkg::uword_t uw;
  logic            take;
  logic            go;

  assign uw   = lps_pkg::ucode(upc_q);
  assign take = uw.accept & in_valid_i;
  assign go   = ~uw.wait_out | out_free_i;

  always_comb begin
    upc_d = upc_q;
    if (uw.dispatch) begin
      if (take) begin
        case (in_cmd_i)
          lps_pkg::CMD_TICK:  upc_d = lps_pkg::UPC_TICK;
          lps_pkg::CMD_WRITE: upc_d = lps_pkg::UPC_WRITE;
          lps_pkg::CMD_START: upc_d = lps_pkg::UPC_START;
          default:            upc_d = lps_pkg::UPC_REPORT;
        endcase
      end
    end else if (go) begin
      upc_d = uw.next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= lps_pkg::UPC_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o.in_ready = uw.accept;
  assign ctrl_o.take     = take;
  assign ctrl_o.commit   = ~uw.accept & go;
  assign ctrl_o.op       = uw.op;

endmodule

`default_nettype wire
